[hw/rtl/ad_pkg.sv]
// ad_pkg: shared constants, codes and types for the array deque
// depends on nothing; imported by every module of the block but ad_ram
`default_nettype none

package ad_pkg;

	localparam int DEPTH   = 8;
	localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int WORD_W  = 32;
	localparam int ACT_W   = 2;
	localparam int STAT_W  = 2;
	localparam int CAP_W   = 4;
	localparam int OCC_W   = 4;
	localparam int LIM_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(5);

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH_FRONT = 2'd0,
		ACT_PUSH_BACK  = 2'd1,
		ACT_POP_FRONT  = 2'd2,
		ACT_POP_BACK   = 2'd3
	} action_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic exec;
	} ad_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/ad_ram.sv]
// ad_ram: generic single write port, single read port ram with registered read
// depends on nothing
`default_nettype none

module ad_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic                       re,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr,
	output logic      [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/ad_ctrl.sv]
// ad_ctrl: controller for the array deque, sequences accept and result cycles
// depends on ad_pkg
`default_nettype none

module ad_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	output logic                 done,
	output ad_pkg::ad_cmd_t      cmd
);

	import ad_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_RESP
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_RESP;
						done    <= 1'b1;
					end
				end
				S_RESP: begin
					state_q <= S_IDLE;
					done    <= 1'b0;
				end
				default: begin
					state_q <= S_IDLE;
					done    <= 1'b0;
				end
			endcase
		end
	end

	assign busy     = (state_q == S_RESP);
	assign cmd.exec = start && (state_q == S_IDLE);

endmodule

`default_nettype wire

[hw/rtl/ad_datapath.sv]
// ad_datapath: pointers, fill count, capacity register and slot ram of the deque
// depends on ad_pkg and ad_ram
`default_nettype none

module ad_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ad_pkg::ad_cmd_t             cmd,
	input  wire logic [ad_pkg::ACT_W-1:0]    action,
	input  wire logic signed [ad_pkg::WORD_W-1:0] value,
	input  wire logic                        wr_en,
	input  wire logic [ad_pkg::CAP_W-1:0]    wr_data,
	output logic [ad_pkg::STAT_W-1:0]        status,
	output logic signed [ad_pkg::WORD_W-1:0] popped,
	output logic [ad_pkg::OCC_W-1:0]         occupancy
);

	import ad_pkg::*;

	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [PTR_W-1:0] head_q, tail_q, head_n, tail_n;
	logic [PTR_W-1:0] waddr, raddr;
	logic [CNT_W-1:0] fill_q, fill_n;
	logic [CAP_W-1:0] cap_q;
	logic [LIM_W-1:0] lim;
	logic             full, empty, we;
	status_t          stat, stat_q;
	logic             pop_ok, pop_ok_q;
	logic [WORD_W-1:0] rdata;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_LAST : p - PTR_W'(1);
	endfunction

	assign lim   = (LIM_W'(cap_q) > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : LIM_W'(cap_q);
	assign full  = LIM_W'(fill_q) >= lim;
	assign empty = (fill_q == '0);

	always_comb begin
		head_n = head_q;
		tail_n = tail_q;
		fill_n = fill_q;
		waddr  = tail_q;
		raddr  = head_q;
		we     = 1'b0;
		pop_ok = 1'b0;
		stat   = ST_OK;
		unique case (action_t'(action))
			ACT_PUSH_FRONT: begin
				waddr = ptr_dec(head_q);
				if (full) begin
					stat = ST_OVERFLOW;
				end else begin
					head_n = ptr_dec(head_q);
					fill_n = fill_q + CNT_W'(1);
					we     = 1'b1;
				end
			end
			ACT_PUSH_BACK: begin
				waddr = tail_q;
				if (full) begin
					stat = ST_OVERFLOW;
				end else begin
					tail_n = ptr_inc(tail_q);
					fill_n = fill_q + CNT_W'(1);
					we     = 1'b1;
				end
			end
			ACT_POP_FRONT: begin
				raddr = head_q;
				if (empty) begin
					stat = ST_UNDERFLOW;
				end else begin
					head_n = ptr_inc(head_q);
					fill_n = fill_q - CNT_W'(1);
					pop_ok = 1'b1;
				end
			end
			ACT_POP_BACK: begin
				raddr = ptr_dec(tail_q);
				if (empty) begin
					stat = ST_UNDERFLOW;
				end else begin
					tail_n = ptr_dec(tail_q);
					fill_n = fill_q - CNT_W'(1);
					pop_ok = 1'b1;
				end
			end
			default: begin
				stat = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			fill_q   <= '0;
			cap_q    <= CAP_RESET;
			stat_q   <= ST_OK;
			pop_ok_q <= 1'b0;
		end else begin
			if (wr_en) begin
				cap_q <= wr_data;
			end
			if (cmd.exec) begin
				head_q   <= head_n;
				tail_q   <= tail_n;
				fill_q   <= fill_n;
				stat_q   <= stat;
				pop_ok_q <= pop_ok;
			end
		end
	end

	ad_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (cmd.exec && we),
		.waddr (waddr),
		.wdata (value),
		.re    (cmd.exec),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign status    = stat_q;
	assign popped    = pop_ok_q ? rdata : '0;
	assign occupancy = OCC_W'(fill_q);

endmodule

`default_nettype wire

[hw/rtl/array_deque.sv]
// array_deque: top level of the double-ended queue over a circular slot ram
// depends on ad_pkg, ad_ctrl, ad_datapath
//
//   channel   handshake              payload
//   request   start, busy            action, value
//   result    done                   status, popped, occupancy
//   config    wr_en                  wr_data (capacity)
//
// an item is taken on start while busy is low; its result shows in the next cycle
// for one cycle with done, from the registered status and the registered read
// of the slot ram. busy is high in the result cycle. reset clears pointers and
// count, sets capacity to five, slot contents stay undefined; no clearing pass.
// the receiver cannot stall the result.
`default_nettype none

module array_deque (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [ad_pkg::ACT_W-1:0]         action,
	input  wire logic signed [ad_pkg::WORD_W-1:0] value,
	output logic                                  done,
	output logic [ad_pkg::STAT_W-1:0]             status,
	output logic signed [ad_pkg::WORD_W-1:0]      popped,
	output logic [ad_pkg::OCC_W-1:0]              occupancy,
	input  wire logic                             wr_en,
	input  wire logic [ad_pkg::CAP_W-1:0]         wr_data
);

	import ad_pkg::*;

	ad_cmd_t cmd;

	ad_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	ad_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.action    (action),
		.value     (value),
		.wr_en     (wr_en),
		.wr_data   (wr_data),
		.status    (status),
		.popped    (popped),
		.occupancy (occupancy)
	);

endmodule

`default_nettype wire

[hw/rtl/ad_checker.sv]
// ad_checker: port level checks of the array deque, bound to the top level
// depends on ad_pkg and array_deque
`default_nettype none

module ad_checker (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             start,
	input wire logic                             busy,
	input wire logic                             done,
	input wire logic [ad_pkg::STAT_W-1:0]        status,
	input wire logic signed [ad_pkg::WORD_W-1:0] popped,
	input wire logic [ad_pkg::OCC_W-1:0]         occupancy
);

	import ad_pkg::*;

	// every accepted item gives its result in the next cycle
	a_accept_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> done)
		else $error("accepted item gave no result");

	// a result lasts one cycle only
	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	// failed operations return no word
	a_fail_no_word: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_OVERFLOW || status == ST_UNDERFLOW) |-> popped == '0)
		else $error("failed operation returned a word");

	// underflow only with an empty deque
	a_underflow_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_UNDERFLOW |-> occupancy == '0)
		else $error("underflow with entries held");

	// no new item is taken while a result is shown
	a_busy_on_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("ready while result shown");

endmodule

bind array_deque ad_checker u_ad_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.status    (status),
	.popped    (popped),
	.occupancy (occupancy)
);

`default_nettype wire

[tb/tb_array_deque.sv]
// tb_array_deque: self-checking testbench for the array_deque double-ended queue
// drives a directed table then random push/pop items, checks every result
// against table rows or a shadow deque model; depends on ad_pkg and array_deque
`timescale 1ns / 100ps

module tb_array_deque;
	import ad_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int ITEMS_PER_PHASE = 85;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		status_t            st;
		logic [WORD_W-1:0] pop;
		logic [OCC_W-1:0]  occ;
	} outcome_t;

	typedef struct packed {
		logic              is_cfg;
		logic [CAP_W-1:0]  cap;
		action_t           act;
		logic [WORD_W-1:0] word;
		logic              has_exp;
		status_t           st;
		logic [WORD_W-1:0] pop;
		logic [OCC_W-1:0]  occ;
	} stim_row_t;

	localparam stim_row_t STIM_TAB [27] = '{
		'{1'b0, 4'd0, ACT_POP_FRONT, 32'h0000_0000, 1'b1, ST_UNDERFLOW, 32'h0, 4'd0},
		'{1'b0, 4'd0, ACT_POP_BACK, 32'hFFFF_FFFF, 1'b1, ST_UNDERFLOW, 32'h0, 4'd0},
		'{1'b0, 4'd0, ACT_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, ST_OK, 32'h0, 4'd1},
		'{1'b0, 4'd0, ACT_POP_BACK, 32'h0000_0000, 1'b1, ST_OK, 32'h7FFF_FFFF, 4'd0},
		'{1'b0, 4'd0, ACT_PUSH_FRONT, 32'h8000_0000, 1'b1, ST_OK, 32'h0, 4'd1},
		'{1'b0, 4'd0, ACT_PUSH_BACK, 32'hFFFF_FFFF, 1'b1, ST_OK, 32'h0, 4'd2},
		'{1'b0, 4'd0, ACT_PUSH_BACK, 32'h0000_0000, 1'b1, ST_OK, 32'h0, 4'd3},
		'{1'b0, 4'd0, ACT_PUSH_FRONT, 32'h0000_0001, 1'b1, ST_OK, 32'h0, 4'd4},
		'{1'b0, 4'd0, ACT_PUSH_BACK, 32'hA5A5_A5A5, 1'b1, ST_OK, 32'h0, 4'd5},
		'{1'b0, 4'd0, ACT_PUSH_FRONT, 32'h0000_0002, 1'b1, ST_OVERFLOW, 32'h0, 4'd5},
		'{1'b0, 4'd0, ACT_POP_FRONT, 32'h1234_5678, 1'b0, ST_OK, 32'h0, 4'd0},
		'{1'b1, 4'd1, ACT_PUSH_FRONT, 32'h0000_0000, 1'b0, ST_OK, 32'h0, 4'd0},
		'{1'b0, 4'd0, ACT_PUSH_BACK, 32'h0000_0003, 1'b1, ST_OVERFLOW, 32'h0, 4'd4},
		'{1'b0, 4'd0, ACT_POP_BACK, 32'h0000_0000, 1'b0, ST_OK, 32'h0, 4'd0},
		'{1'b0, 4'd0, ACT_POP_FRONT, 32'h0000_0000, 1'b0, ST_OK, 32'h0, 4'd0},
		'{1'b0, 4'd0, ACT_POP_FRONT, 32'h0000_0000, 1'b0, ST_OK, 32'h0, 4'd0},
		'{1'b0, 4'd0, ACT_POP_BACK, 32'h0000_0000, 1'b0, ST_OK, 32'h0, 4'd0},
		'{1'b0, 4'd0, ACT_PUSH_BACK, 32'h5A5A_5A5A, 1'b1, ST_OK, 32'h0, 4'd1},
		'{1'b0, 4'd0, ACT_PUSH_FRONT, 32'h0000_0004, 1'b1, ST_OVERFLOW, 32'h0, 4'd1},
		'{1'b1, 4'd0, ACT_PUSH_FRONT, 32'h0000_0000, 1'b0, ST_OK, 32'h0, 4'd0},
		'{1'b0, 4'd0, ACT_PUSH_BACK, 32'h0000_0006, 1'b1, ST_OVERFLOW, 32'h0, 4'd1},
		'{1'b0, 4'd0, ACT_POP_FRONT, 32'h0000_0000, 1'b0, ST_OK, 32'h0, 4'd0},
		'{1'b0, 4'd0, ACT_POP_BACK, 32'h0000_0000, 1'b1, ST_UNDERFLOW, 32'h0, 4'd0},
		'{1'b1, 4'd15, ACT_PUSH_FRONT, 32'h0000_0000, 1'b0, ST_OK, 32'h0, 4'd0},
		'{1'b0, 4'd0, ACT_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, ST_OK, 32'h0, 4'd0},
		'{1'b0, 4'd0, ACT_PUSH_BACK, 32'h8000_0000, 1'b0, ST_OK, 32'h0, 4'd0},
		'{1'b0, 4'd0, ACT_PUSH_FRONT, 32'h7FFF_FFFF, 1'b0, ST_OK, 32'h0, 4'd0}
	};

	localparam logic [CAP_W-1:0] CAP_PLAN [12] = '{
		4'd8, 4'd15, 4'd1, 4'd3, 4'd0, 4'd5, 4'd8, 4'd2, 4'd15, 4'd6, 4'd4, 4'd7
	};
	localparam int IDLE_PLAN [4] = '{0, 69, 0, 11};
	localparam logic [WORD_W-1:0] CORNER_WORDS [4] = '{
		32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF
	};

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [ACT_W-1:0]         action;
	logic signed [WORD_W-1:0] value;
	logic                     done;
	logic [STAT_W-1:0]        status;
	logic signed [WORD_W-1:0] popped;
	logic [OCC_W-1:0]         occupancy;
	logic                     wr_en;
	logic [CAP_W-1:0]         wr_data;

	logic [WORD_W-1:0] shadow_slots [DEPTH];
	int                shadow_head;
	int                shadow_tail;
	int                shadow_fill;
	int                shadow_cap;
	outcome_t          pending_outcomes [$];
	int                mismatches = 0;
	int                cycle_count = 0;

	array_deque DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.action    (action),
		.value     (value),
		.done      (done),
		.status    (status),
		.popped    (popped),
		.occupancy (occupancy),
		.wr_en     (wr_en),
		.wr_data   (wr_data)
	);

	always #5 clk = ~clk;

	function automatic outcome_t apply_op(action_t act, logic [WORD_W-1:0] word);
		outcome_t r;
		int       lim;
		r.st = ST_OK;
		r.pop = '0;
		lim = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
		if (act == ACT_PUSH_FRONT || act == ACT_PUSH_BACK) begin
			if (shadow_fill >= lim) begin
				r.st = ST_OVERFLOW;
			end else if (act == ACT_PUSH_FRONT) begin
				shadow_head = (shadow_head == 0) ? DEPTH - 1 : shadow_head - 1;
				shadow_slots[shadow_head] = word;
				shadow_fill++;
			end else begin
				shadow_slots[shadow_tail] = word;
				shadow_tail = (shadow_tail == DEPTH - 1) ? 0 : shadow_tail + 1;
				shadow_fill++;
			end
		end else begin
			if (shadow_fill == 0) begin
				r.st = ST_UNDERFLOW;
			end else if (act == ACT_POP_FRONT) begin
				r.pop = shadow_slots[shadow_head];
				shadow_head = (shadow_head == DEPTH - 1) ? 0 : shadow_head + 1;
				shadow_fill--;
			end else begin
				shadow_tail = (shadow_tail == 0) ? DEPTH - 1 : shadow_tail - 1;
				r.pop = shadow_slots[shadow_tail];
				shadow_fill--;
			end
		end
		r.occ = OCC_W'(shadow_fill);
		return r;
	endfunction

	task automatic send_op(action_t act, logic [WORD_W-1:0] word, logic has_exp,
			outcome_t hand);
		outcome_t r;
		start <= 1'b1;
		action <= act;
		value <= word;
		do @(posedge clk); while (busy);
		r = apply_op(act, word);
		pending_outcomes.push_back(has_exp ? hand : r);
	endtask

	task automatic set_capacity(logic [CAP_W-1:0] cap);
		start <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
		wr_en <= 1'b1;
		wr_data <= cap;
		@(posedge clk);
		wr_en <= 1'b0;
		shadow_cap = cap;
	endtask

	always @(posedge clk) begin
		outcome_t exp_r;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: result with no item pending: status %0d popped %h occ %0d",
						$realtime, status, popped, occupancy);
			end else begin
				exp_r = pending_outcomes.pop_front();
				if (status !== exp_r.st || popped !== exp_r.pop || occupancy !== exp_r.occ) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: expected status %0d popped %h occ %0d, got %0d %h %0d",
							$realtime, exp_r.st, exp_r.pop, exp_r.occ,
							status, popped, occupancy);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("** array_deque: FAILED **");
			$finish;
		end
	end

	initial begin
		action_t           act;
		logic [WORD_W-1:0] word;
		int                push_pct;
		int                idle_pct;
		arst_n = 1'b0;
		start = 1'b0;
		action = '0;
		value = '0;
		wr_en = 1'b0;
		wr_data = '0;
		shadow_head = 0;
		shadow_tail = 0;
		shadow_fill = 0;
		shadow_cap = CAP_RESET;
		foreach (shadow_slots[k]) shadow_slots[k] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (STIM_TAB[k]) begin
			if (STIM_TAB[k].is_cfg)
				set_capacity(STIM_TAB[k].cap);
			else
				send_op(STIM_TAB[k].act, STIM_TAB[k].word, STIM_TAB[k].has_exp,
					'{STIM_TAB[k].st, STIM_TAB[k].pop, STIM_TAB[k].occ});
		end

		push_pct = 50;
		foreach (CAP_PLAN[ph]) begin
			set_capacity(CAP_PLAN[ph]);
			idle_pct = IDLE_PLAN[ph % 4];
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				// swing between filling and draining so full and empty both get hit
				if ($urandom_range(15) == 0)
					push_pct = ($urandom_range(2) == 0) ? 50 : ($urandom_range(1) ? 80 : 20);
				if ($urandom_range(99) < push_pct)
					act = action_t'($urandom_range(1));
				else
					act = action_t'(2 + $urandom_range(1));
				word = ($urandom_range(7) == 0) ? CORNER_WORDS[$urandom_range(3)] : $urandom;
				while ($urandom_range(99) < idle_pct) begin
					start <= 1'b0;
					@(posedge clk);
				end
				send_op(act, word, 1'b0, '0);
			end
		end

		start <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatches == 0)
			$display("** array_deque: PASSED **");
		else
			$display("** array_deque: FAILED **");
		$finish;
	end

endmodule

[array_deque.f]
hw/rtl/ad_pkg.sv
hw/rtl/ad_ram.sv
hw/rtl/ad_ctrl.sv
hw/rtl/ad_datapath.sv
hw/rtl/array_deque.sv
hw/rtl/ad_checker.sv
tb/tb_array_deque.sv
